/* rtl/jsed_pkg.sv */
// jsed_pkg: shared types, codes and decode functions for the json string escape decoder
// no dependencies; used by jsed_step, jsed_outbuf and json_string_escape_decoder
`default_nettype none

package jsed_pkg;

  // parser modes, one-hot
  typedef enum logic [8:0] {
    M_TEXT      = 9'b000000001,
    M_ESC       = 9'b000000010,
    M_XHEX      = 9'b000000100,
    M_UHEX      = 9'b000001000,
    M_LOW_BS    = 9'b000010000,
    M_LOW_U     = 9'b000100000,
    M_LOWHEX    = 9'b001000000,
    M_END_QUOTE = 9'b010000000,
    M_END_ERR   = 9'b100000000
  } mode_t;

  // status codes
  localparam logic [1:0] ST_CONT    = 2'd0;
  localparam logic [1:0] ST_QUOTE   = 2'd1;
  localparam logic [1:0] ST_SRC_END = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6e;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_ESCAPE = 8'h1b;

  // surrogate ranges
  localparam logic [15:0] HI_SURR_MIN = 16'hd800;
  localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
  localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
  localparam logic [15:0] LO_SURR_MAX = 16'hdfff;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // one decoded group: up to four bytes, first byte in bytes[0]
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic            byte_valid;
    logic [1:0]      status;
  } group_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
  } enc_t;

  // {ok, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  // {ok, byte}
  function automatic logic [8:0] single_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CH_QUOTE: r = {1'b1, CH_QUOTE};
      CH_BSL:   r = {1'b1, CH_BSL};
      CH_SLASH: r = {1'b1, CH_SLASH};
      CH_LC_B:  r = {1'b1, 8'h08};
      CH_LC_F:  r = {1'b1, 8'h0c};
      CH_LC_N:  r = {1'b1, 8'h0a};
      CH_LC_R:  r = {1'b1, 8'h0d};
      CH_LC_T:  r = {1'b1, 8'h09};
      CH_LC_E:  r = {1'b1, CH_ESCAPE};
      CH_APOS:  r = {1'b1, CH_APOS};
      default:  r = 9'b0;
    endcase
    return r;
  endfunction

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.cnt_m1   = 2'd0;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.cnt_m1   = 2'd1;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.cnt_m1   = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.cnt_m1   = 2'd3;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/jsed_step.sv */
// jsed_step: parser state registers and the per-byte decode logic
// depends on jsed_pkg
`default_nettype none

module jsed_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_src_last,
  output jsed_pkg::group_t    grp
);

  jsed_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  dig_r, dig_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic [4:0]  hv;
  logic [8:0]  se;
  logic [15:0] acc_sh;
  logic [2:0]  dig_inc;
  logic [20:0] cp_pair;
  jsed_pkg::enc_t enc_u, enc_p;

  logic [3:0][7:0] bytes;
  logic [1:0]  cnt;
  logic        has;
  logic [1:0]  st;
  logic        err;

  assign hv      = jsed_pkg::hex_value(in_byte);
  assign se      = jsed_pkg::single_escape(in_byte);
  assign acc_sh  = {acc_r[11:0], hv[3:0]};
  assign dig_inc = dig_r + 3'd1;
  assign cp_pair = {1'b0, hs_r, acc_sh[9:0]} + jsed_pkg::SUPP_BASE;
  assign enc_u   = jsed_pkg::utf8_encode({5'b0, acc_sh});
  assign enc_p   = jsed_pkg::utf8_encode(cp_pair);

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    hs_nxt   = hs_r;
    bytes    = '0;
    cnt      = 2'd0;
    has      = 1'b0;
    st       = jsed_pkg::ST_CONT;
    err      = 1'b0;

    unique case (mode_r)
      jsed_pkg::M_ESC: begin
        if (se[8]) begin
          bytes[0] = se[7:0];
          has      = 1'b1;
          mode_nxt = jsed_pkg::M_TEXT;
        end else if (in_byte == jsed_pkg::CH_LC_X) begin
          mode_nxt = jsed_pkg::M_XHEX;
          acc_nxt  = '0;
          dig_nxt  = '0;
        end else if (in_byte == jsed_pkg::CH_LC_U) begin
          mode_nxt = jsed_pkg::M_UHEX;
          acc_nxt  = '0;
          dig_nxt  = '0;
        end else begin
          err = 1'b1;
        end
      end
      jsed_pkg::M_XHEX: begin
        if (!hv[4]) begin
          err = 1'b1;
        end else begin
          acc_nxt = acc_sh;
          dig_nxt = dig_inc;
          if (dig_inc >= 3'd2) begin
            bytes[0] = acc_sh[7:0];
            has      = 1'b1;
            mode_nxt = jsed_pkg::M_TEXT;
          end
        end
      end
      jsed_pkg::M_UHEX: begin
        if (!hv[4]) begin
          err = 1'b1;
        end else begin
          acc_nxt = acc_sh;
          dig_nxt = dig_inc;
          if (dig_inc >= 3'd4) begin
            if (acc_sh >= jsed_pkg::HI_SURR_MIN && acc_sh <= jsed_pkg::HI_SURR_MAX) begin
              // high surrogate: low 10 bits are the offset from the range base
              hs_nxt   = acc_sh[9:0];
              mode_nxt = jsed_pkg::M_LOW_BS;
            end else begin
              bytes    = enc_u.bytes;
              cnt      = enc_u.cnt_m1;
              has      = 1'b1;
              mode_nxt = jsed_pkg::M_TEXT;
            end
          end
        end
      end
      jsed_pkg::M_LOW_BS: begin
        if (in_byte == jsed_pkg::CH_BSL) mode_nxt = jsed_pkg::M_LOW_U;
        else err = 1'b1;
      end
      jsed_pkg::M_LOW_U: begin
        if (in_byte == jsed_pkg::CH_LC_U) begin
          mode_nxt = jsed_pkg::M_LOWHEX;
          acc_nxt  = '0;
          dig_nxt  = '0;
        end else begin
          err = 1'b1;
        end
      end
      jsed_pkg::M_LOWHEX: begin
        if (!hv[4]) begin
          err = 1'b1;
        end else begin
          acc_nxt = acc_sh;
          dig_nxt = dig_inc;
          if (dig_inc >= 3'd4) begin
            if (acc_sh < jsed_pkg::LO_SURR_MIN || acc_sh > jsed_pkg::LO_SURR_MAX) begin
              err = 1'b1;
            end else begin
              bytes    = enc_p.bytes;
              cnt      = enc_p.cnt_m1;
              has      = 1'b1;
              mode_nxt = jsed_pkg::M_TEXT;
            end
          end
        end
      end
      jsed_pkg::M_END_QUOTE: st = jsed_pkg::ST_QUOTE;
      jsed_pkg::M_END_ERR:   st = jsed_pkg::ST_ERROR;
      default: begin
        mode_nxt = jsed_pkg::M_TEXT;
        if (in_byte == jsed_pkg::CH_QUOTE) begin
          st       = jsed_pkg::ST_QUOTE;
          mode_nxt = jsed_pkg::M_END_QUOTE;
        end else if (in_byte == jsed_pkg::CH_BSL) begin
          mode_nxt = jsed_pkg::M_ESC;
        end else begin
          bytes[0] = in_byte;
          has      = 1'b1;
        end
      end
    endcase

    if (err) begin
      has      = 1'b0;
      st       = jsed_pkg::ST_ERROR;
      mode_nxt = jsed_pkg::M_END_ERR;
    end

    if (in_src_last) begin
      // pending escape at source end is a truncation error
      if (st == jsed_pkg::ST_CONT)
        st = (mode_nxt == jsed_pkg::M_TEXT) ? jsed_pkg::ST_SRC_END : jsed_pkg::ST_ERROR;
      if (st == jsed_pkg::ST_ERROR) has = 1'b0;
      mode_nxt = jsed_pkg::M_TEXT;
      acc_nxt  = '0;
      dig_nxt  = '0;
      hs_nxt   = '0;
    end

    grp.bytes      = has ? bytes : '0;
    grp.cnt_m1     = has ? cnt : 2'd0;
    grp.byte_valid = has;
    grp.status     = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsed_pkg::M_TEXT;
      acc_r  <= '0;
      dig_r  <= '0;
      hs_r   <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
      hs_r   <= hs_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/jsed_outbuf.sv */
// jsed_outbuf: result register that sends one decoded group out a byte at a time
// depends on jsed_pkg
`default_nettype none

module jsed_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire jsed_pkg::group_t  grp,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic [1:0]             out_status,
  output logic                   out_run_last
);

  logic             vld_r, vld_nxt;
  logic [1:0]       rem_r, rem_nxt;
  jsed_pkg::group_t grp_r;
  logic             fin;
  logic             fire;

  assign fin      = (rem_r == 2'd0);
  assign fire     = vld_r && out_ready;
  assign can_load = !vld_r || (out_ready && fin);

  assign out_valid      = vld_r;
  assign out_byte       = grp_r.bytes[0];
  assign out_byte_valid = grp_r.byte_valid;
  assign out_status     = fin ? grp_r.status : jsed_pkg::ST_CONT;
  assign out_run_last   = fin;

  always_comb begin
    vld_nxt = vld_r;
    rem_nxt = rem_r;
    if (load) begin
      vld_nxt = 1'b1;
      rem_nxt = grp.cnt_m1;
    end else if (fire) begin
      if (fin) vld_nxt = 1'b0;
      else rem_nxt = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

  // payload: load a new group or shift the next byte to the front
  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end else if (fire && !fin) begin
      grp_r.bytes <= {8'h00, grp_r.bytes[3:1]};
    end
  end

endmodule

`default_nettype wire

/* rtl/json_string_escape_decoder.sv */
// json_string_escape_decoder: top level of the string literal unescaper
// depends on jsed_pkg, jsed_step and jsed_outbuf
`default_nettype none

// Decodes the body of a JSON / C string literal, one source byte per transaction
// on the in_ channel. Ordinary bytes pass through, an unescaped quote ends the
// string, and backslash escapes (single-character, \x with two hex digits, \u
// with four hex digits, surrogate pairs combined) are decoded, \u code points
// being sent as UTF-8. Each input byte gives one to four result transactions on
// the out_ channel; out_run_last marks the final one and only it carries a
// nonzero out_status (1 quote, 2 source end, 3 error). A byte that decodes
// nothing gives a single result with out_byte_valid low. After the ending quote
// or an error, bytes are consumed with the same status until in_src_last, which
// returns the parser to its reset state. Rate: an input byte is taken every
// cycle while out_ready is high and each byte yields a single result; a byte that
// yields more than one UTF-8 byte holds the input until the result register,
// which sends one byte per cycle while out_ready is high, has sent the last.
module json_string_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_src_last,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic [1:0]      out_status,
  output logic            out_run_last
);

  jsed_pkg::group_t grp;
  logic             can_load;
  logic             take;

  // a new byte is taken when the result register is empty or frees this cycle
  assign in_ready = can_load;
  assign take     = in_valid && can_load;

  // parser state and combinational decode of the current byte
  jsed_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .in_byte     (in_byte),
    .in_src_last (in_src_last),
    .grp         (grp)
  );

  // result register, serializes multi-byte groups
  jsed_outbuf u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (take),
    .grp            (grp),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_run_last   (out_run_last)
  );

endmodule

`default_nettype wire
